>>> rtl/rscw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscw_pkg
// Shared widths, constants and types for the rational soft-clip waveshaper.
// ----------------------------------------------------------------------------
package rscw_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 20;
    localparam int DRIVE_W    = 13;
    localparam int DRIVE_FRAC = 8;
    localparam int MIX_W      = 13;
    localparam int MIX_FRAC   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // internal datapath widths
    localparam int DRY_W     = FRAC_W + 1;
    localparam int DRY_SHIFT = SAMPLE_W - 1 - FRAC_W;
    localparam int P1_W      = DRY_W + DRIVE_W + 1;
    localparam int X_W       = P1_W - DRIVE_FRAC;
    localparam int MAG_W     = FRAC_W + DRIVE_W - DRIVE_FRAC;
    localparam int S2_W      = 2 * MAG_W - FRAC_W;
    localparam int T_W       = S2_W + 1;
    localparam int NUM_W     = MAG_W + T_W - FRAC_W;
    localparam int DEN_W     = S2_W + 4;
    localparam int DIVN_W    = NUM_W + FRAC_W;
    localparam int Q_W       = MAG_W;
    localparam int MK_W      = FRAC_W + 4;
    localparam int W_W       = Q_W + MK_W - FRAC_W;
    localparam int WET_W     = W_W + 1;
    localparam int DIFF_W    = WET_W + 1;
    localparam int PROD_W    = DIFF_W + MIX_W + 1;
    localparam int SH_W      = PROD_W - MIX_FRAC;
    localparam int Y_W       = SH_W + 1;
    localparam int YO_W      = Y_W + DRY_SHIFT;
    localparam int KD_W      = 2 * FRAC_W;
    localparam int CNT_W     = $clog2(MK_W);

    localparam logic [T_W-1:0]    C27_T  = T_W'(27) << FRAC_W;
    localparam logic [DEN_W-1:0]  C27_D  = DEN_W'(27) << FRAC_W;
    localparam logic [FRAC_W-1:0] K_MK   = FRAC_W'((84 * (2 ** FRAC_W) + 50) / 100);
    localparam logic [MK_W-1:0]   MK_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ON = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX       = 2'd2;

    localparam logic                EFFECT_RESET = 1'b1;
    localparam logic [DRIVE_W-1:0]  DRIVE_RESET  = 13'd256;
    localparam logic [MIX_W-1:0]    MIX_RESET    = 13'd0;

    typedef struct packed {
        logic                     cfg;
        logic                     neg;
        logic signed [DRY_W-1:0]  dry;
    } t_side;

    typedef struct packed {
        logic busy;
        logic launch;
    } t_mk_ctrl;

endpackage
`default_nettype wire

>>> rtl/rscw_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscw_front
// Drive gain, magnitude, square and numerator/denominator of the curve.
// ----------------------------------------------------------------------------
module rscw_front (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_load,
    input  wire logic                            i_launch,
    input  wire logic [rscw_pkg::SAMPLE_W-1:0]   i_sample_in,
    input  wire logic [rscw_pkg::DRIVE_W-1:0]    i_drive,
    output logic                                 o_vld,
    output rscw_pkg::t_side                      o_side,
    output logic [rscw_pkg::NUM_W-1:0]           o_num,
    output logic [rscw_pkg::DEN_W-1:0]           o_den
);
    import rscw_pkg::*;

    logic                        r_v1, r_v2, r_v3, r_v4;
    t_side                       r_s1, r_s2, r_s3, r_s4;
    t_side                       n_s1, n_s2;
    logic signed [P1_W-1:0]      r_p1, n_p1;
    logic [MAG_W-1:0]            r_m2, n_m2, r_m3;
    logic [S2_W-1:0]             r_sq3, n_sq3;
    logic [NUM_W-1:0]            r_num4, n_num4;
    logic [DEN_W-1:0]            r_den4, n_den4;

    logic signed [DRY_W-1:0]     dry;
    logic [X_W-1:0]              xs, xa;
    logic [2*MAG_W-1:0]          sq;
    logic [T_W-1:0]              t_sum;
    logic [MAG_W+T_W-1:0]        pr;

    // stage 1: drive gain (or the drive value itself for a makeup token)
    assign dry = i_sample_in[SAMPLE_W-1:DRY_SHIFT];

    always_comb begin
        if (i_launch) begin
            n_p1 = $signed({{(P1_W-DRIVE_W-FRAC_W){1'b0}}, i_drive, {FRAC_W{1'b0}}});
        end else begin
            n_p1 = dry * $signed({1'b0, i_drive});
        end
        n_s1.cfg = i_launch;
        n_s1.neg = 1'b0;
        n_s1.dry = dry;
    end

    // stage 2: floor shift and magnitude
    assign xs = r_p1[P1_W-1:DRIVE_FRAC];
    assign xa = xs[X_W-1] ? (~xs + 1'b1) : xs;

    always_comb begin
        n_s2     = r_s1;
        n_s2.neg = xs[X_W-1];
        n_m2     = xa[MAG_W-1:0];
    end

    // stage 3: square
    assign sq    = r_m2 * r_m2;
    assign n_sq3 = sq[2*MAG_W-1:FRAC_W];

    // stage 4: numerator and denominator
    assign t_sum  = C27_T + T_W'(r_sq3);
    assign pr     = r_m3 * t_sum;
    assign n_num4 = pr[MAG_W+T_W-1:FRAC_W];
    assign n_den4 = C27_D + (DEN_W'(r_sq3) << 3) + DEN_W'(r_sq3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_load | i_launch;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1   <= n_s1;
            r_p1   <= n_p1;
            r_s2   <= n_s2;
            r_m2   <= n_m2;
            r_s3   <= r_s2;
            r_m3   <= r_m2;
            r_sq3  <= n_sq3;
            r_s4   <= r_s3;
            r_num4 <= n_num4;
            r_den4 <= n_den4;
        end
    end

    assign o_vld  = r_v4;
    assign o_side = r_s4;
    assign o_num  = r_num4;
    assign o_den  = r_den4;

endmodule
`default_nettype wire

>>> rtl/rscw_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscw_divider
// Pipelined restoring divider, one quotient bit per stage: num * 2^F / den.
// ----------------------------------------------------------------------------
module rscw_divider (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire rscw_pkg::t_side               i_side,
    input  wire logic [rscw_pkg::NUM_W-1:0]    i_num,
    input  wire logic [rscw_pkg::DEN_W-1:0]    i_den,
    output logic                               o_vld,
    output rscw_pkg::t_side                    o_side,
    output logic [rscw_pkg::Q_W-1:0]           o_q
);
    import rscw_pkg::*;

    logic                r_vld  [Q_W];
    t_side               r_side [Q_W];
    logic [DEN_W-1:0]    r_rem  [Q_W];
    logic [Q_W-1:0]      r_lo   [Q_W];
    logic [DEN_W-1:0]    r_den  [Q_W];

    logic [DIVN_W-1:0]   dividend;

    assign dividend = {i_num, {FRAC_W{1'b0}}};

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic              vld_in;
        t_side             side_in;
        logic [DEN_W-1:0]  rem_in;
        logic [Q_W-1:0]    lo_in;
        logic [DEN_W-1:0]  den_in;
        logic [DEN_W:0]    cand;
        logic              ge;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign side_in = i_side;
            assign rem_in  = DEN_W'(dividend[DIVN_W-1:Q_W]);
            assign lo_in   = dividend[Q_W-1:0];
            assign den_in  = i_den;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign side_in = r_side[k-1];
            assign rem_in  = r_rem[k-1];
            assign lo_in   = r_lo[k-1];
            assign den_in  = r_den[k-1];
        end

        assign cand = {rem_in, lo_in[Q_W-1]};
        assign ge   = cand >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= side_in;
                r_den[k]  <= den_in;
                r_rem[k]  <= ge ? DEN_W'(cand - {1'b0, den_in}) : cand[DEN_W-1:0];
                r_lo[k]   <= {lo_in[Q_W-2:0], ge};
            end
        end
    end

    assign o_vld  = r_vld[Q_W-1];
    assign o_side = r_side[Q_W-1];
    assign o_q    = r_lo[Q_W-1];

endmodule
`default_nettype wire

>>> rtl/rscw_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscw_back
// Makeup gain, dry/wet blend and output saturation.
// ----------------------------------------------------------------------------
module rscw_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire rscw_pkg::t_side               i_side,
    input  wire logic [rscw_pkg::Q_W-1:0]      i_q,
    input  wire logic [rscw_pkg::MK_W-1:0]     i_makeup,
    input  wire logic [rscw_pkg::MIX_W-1:0]    i_mix_eff,
    output logic                               o_vld,
    output logic [rscw_pkg::SAMPLE_W-1:0]      o_sample
);
    import rscw_pkg::*;

    logic                       r_wv;
    t_side                      r_wside;
    logic [W_W-1:0]             r_w, n_w;
    logic                       r_mv;
    logic                       r_mcfg;
    logic signed [DRY_W-1:0]    r_mdry;
    logic signed [PROD_W-1:0]   r_prod, n_prod;

    logic [Q_W+MK_W-1:0]        pw;
    logic signed [WET_W-1:0]    wet;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [SH_W-1:0]     sh;
    logic signed [Y_W-1:0]      y;
    logic signed [YO_W-1:0]     yo;
    logic [YO_W-SAMPLE_W:0]     hi;
    logic                       fits;

    assign pw  = i_q * i_makeup;
    assign n_w = pw[Q_W+MK_W-1:FRAC_W];

    assign wet    = r_wside.neg ? -$signed({1'b0, r_w}) : $signed({1'b0, r_w});
    assign diff   = DIFF_W'(wet) - DIFF_W'(r_wside.dry);
    assign n_prod = diff * $signed({1'b0, i_mix_eff});

    // floor shift of the blend term, back to sample scale, saturate
    assign sh   = r_prod[PROD_W-1:MIX_FRAC];
    assign y    = Y_W'(sh) + Y_W'(r_mdry);
    assign yo   = {y, {DRY_SHIFT{1'b0}}};
    assign hi   = yo[YO_W-1:SAMPLE_W-1];
    assign fits = (&hi) | ~(|hi);

    always_comb begin
        if (fits) begin
            o_sample = yo[SAMPLE_W-1:0];
        end else if (yo[YO_W-1]) begin
            o_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    assign o_vld = r_mv & ~r_mcfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
            r_mv <= 1'b0;
        end else if (i_en) begin
            r_wv <= i_vld;
            r_mv <= r_wv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wside <= i_side;
            r_w     <= n_w;
            r_mcfg  <= r_wside.cfg;
            r_mdry  <= r_wside.dry;
            r_prod  <= n_prod;
        end
    end

endmodule
`default_nettype wire

>>> rtl/rscw_makeup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rscw_makeup
// Makeup gain sequencer: sends the drive through the curve pipeline, then
// divides 0.84 by the result one bit a cycle, saturating to Q4.F.
// ----------------------------------------------------------------------------
module rscw_makeup (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_start,
    input  wire logic                         i_tok_vld,
    input  wire logic [rscw_pkg::Q_W-1:0]     i_tok_q,
    output rscw_pkg::t_mk_ctrl                o_ctrl,
    output logic [rscw_pkg::MK_W-1:0]         o_makeup
);
    import rscw_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LAUNCH = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_DIV    = 4'b1000
    } t_mk_state;

    t_mk_state           r_state, n_state;
    logic [Q_W-1:0]      r_qd;
    logic [Q_W-1:0]      r_rem, n_rem;
    logic [MK_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]    r_cnt;
    logic [MK_W-1:0]     r_makeup;

    logic [KD_W-1:0]     kn;
    logic [Q_W-1:0]      rem0;
    logic                sat;
    logic [Q_W:0]        cand;
    logic                ge;

    assign kn   = {K_MK, {FRAC_W{1'b0}}};
    assign rem0 = Q_W'(kn[KD_W-1:MK_W]);
    assign sat  = rem0 >= i_tok_q;

    assign cand  = {r_rem, r_lo[MK_W-1]};
    assign ge    = cand >= {1'b0, r_qd};
    assign n_rem = ge ? Q_W'(cand - {1'b0, r_qd}) : cand[Q_W-1:0];
    assign n_lo  = {r_lo[MK_W-2:0], ge};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_LAUNCH;
            end
            ST_LAUNCH: begin
                if (i_en) n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_tok_vld) n_state = sat ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == '0) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // reset starts a computation for the reset drive value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LAUNCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_WAIT: begin
                if (i_tok_vld) begin
                    r_qd  <= i_tok_q;
                    r_rem <= rem0;
                    r_lo  <= kn[MK_W-1:0];
                    r_cnt <= CNT_W'(MK_W - 1);
                    if (sat) r_makeup <= MK_MAX;
                end
            end
            ST_DIV: begin
                r_rem <= n_rem;
                r_lo  <= n_lo;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) r_makeup <= n_lo;
            end
            default: ;
        endcase
    end

    assign o_ctrl.busy   = (r_state != ST_IDLE);
    assign o_ctrl.launch = (r_state == ST_LAUNCH);
    assign o_makeup      = r_makeup;

endmodule
`default_nettype wire

>>> rtl/rational_soft_clip_waveshaper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rational_soft_clip_waveshaper
// Drive, rational tanh soft clip, makeup gain and dry/wet mix on Q1.23 audio.
// ----------------------------------------------------------------------------
// One sample per clock once running, unless a full skid stage or a makeup
// recompute holds the input; each result passes through 4 curve stages, 25
// divider stages, 2 mix stages and the output register, and a skid stage
// holds a result while the output stalls. After reset and after every
// drive_gain write the makeup gain is recomputed: the drive value is sent
// once through the curve pipeline and then divided into 0.84 by a bit-serial
// divider; until that is done neither samples nor further register writes
// are taken.
// ----------------------------------------------------------------------------
module rational_soft_clip_waveshaper (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_ready,
    input  wire logic signed [rscw_pkg::SAMPLE_W-1:0]   i_sample_in,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_ready,
    output logic signed [rscw_pkg::SAMPLE_W-1:0]        o_sample_out,
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [rscw_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [rscw_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import rscw_pkg::*;

    logic                   r_effect_on;
    logic [DRIVE_W-1:0]     r_drive;
    logic [MIX_W-1:0]       r_mix;
    logic                   r_out_vld, r_skid_vld;
    logic [SAMPLE_W-1:0]    r_out_data, r_skid_data;

    logic                   en;
    logic                   in_xfer;
    logic                   cfg_xfer;
    logic                   drive_wr;
    logic [MIX_W-1:0]       mix_eff;
    t_mk_ctrl               mk_ctrl;
    logic [MK_W-1:0]        makeup;

    logic                   fr_vld;
    t_side                  fr_side;
    logic [NUM_W-1:0]       fr_num;
    logic [DEN_W-1:0]       fr_den;
    logic                   dv_vld;
    t_side                  dv_side;
    logic [Q_W-1:0]         dv_q;
    logic                   bk_vld;
    logic [SAMPLE_W-1:0]    bk_sample;

    // pipeline advances while the skid stage is empty
    assign en          = ~r_skid_vld;
    assign o_in_ready  = en & ~mk_ctrl.busy;
    assign in_xfer     = i_in_valid & o_in_ready;
    assign o_cfg_ready = ~mk_ctrl.busy;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;
    assign drive_wr    = cfg_xfer && (i_cfg_index == REG_DRIVE);
    assign mix_eff     = r_effect_on ? r_mix : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_on <= EFFECT_RESET;
            r_drive     <= DRIVE_RESET;
            r_mix       <= MIX_RESET;
        end else if (cfg_xfer) begin
            unique case (i_cfg_index)
                REG_EFFECT_ON: r_effect_on <= i_cfg_data[0];
                REG_DRIVE:     r_drive     <= i_cfg_data[DRIVE_W-1:0];
                REG_MIX:       r_mix       <= i_cfg_data[MIX_W-1:0];
                default: ;
            endcase
        end
    end

    rscw_makeup u_makeup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_start   (drive_wr),
        .i_tok_vld (dv_vld & dv_side.cfg),
        .i_tok_q   (dv_q),
        .o_ctrl    (mk_ctrl),
        .o_makeup  (makeup)
    );

    rscw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_load      (in_xfer),
        .i_launch    (mk_ctrl.launch),
        .i_sample_in (i_sample_in),
        .i_drive     (r_drive),
        .o_vld       (fr_vld),
        .o_side      (fr_side),
        .o_num       (fr_num),
        .o_den       (fr_den)
    );

    rscw_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (fr_vld),
        .i_side  (fr_side),
        .i_num   (fr_num),
        .i_den   (fr_den),
        .o_vld   (dv_vld),
        .o_side  (dv_side),
        .o_q     (dv_q)
    );

    rscw_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_vld     (dv_vld),
        .i_side    (dv_side),
        .i_q       (dv_q),
        .i_makeup  (makeup),
        .i_mix_eff (mix_eff),
        .o_vld     (bk_vld),
        .o_sample  (bk_sample)
    );

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_out_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= bk_vld;
            end
        end else if (bk_vld && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_out_ready) begin
            if (r_skid_vld) begin
                r_out_data <= r_skid_data;
            end else begin
                r_out_data <= bk_sample;
            end
        end else if (!r_skid_vld) begin
            r_skid_data <= bk_sample;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_sample_out = r_out_data;

    a_skid_implies_out: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld
    ) else $error("skid stage full while output register empty");

    a_skid_fill_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_out_ready)
    ) else $error("skid stage filled without an output stall");

    a_drive_write_recompute: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && (i_cfg_index == REG_DRIVE)) |=> mk_ctrl.busy
    ) else $error("drive write did not start a makeup recompute");

endmodule
`default_nettype wire

>>> verif/rational_soft_clip_waveshaper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_soft_clip_waveshaper_tb
// Checks every shaped sample against a hard-coded result or a bit-exact model of the
// drive, rational soft clip, makeup gain and dry/wet mix, across a directed
// table of edge cases and randomised register settings and samples, with
// random gaps on the input, output and register channels.
// ----------------------------------------------------------------------------
module rational_soft_clip_waveshaper_tb;

    import rscw_pkg::*;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        t_sample                 sample;
        logic                    known;
        t_sample                 result;
    } t_stim_row;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam t_sample S_MAX = 24'sh7FFFFF;
    localparam t_sample S_MIN = 24'sh800000;
    localparam int      IN_SHIFT = SAMPLE_W - 1 - FRAC_W;

    localparam longint C27      = longint'(27) <<< FRAC_W;
    localparam longint K_HEAD   = (84 * (longint'(1) <<< FRAC_W) + 50) / 100;
    localparam longint GAIN_MAX = (longint'(1) <<< (FRAC_W + 4)) - 1;
    localparam longint QUOT_SAT = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 40;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 75;
    localparam int N_DIRECTED   = 36;

    localparam t_stim_row DIRECTED [N_DIRECTED] = '{
        // after reset: mix is zero, output is the dry sample
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd0,        1'b1, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MAX,         1'b1, 24'sd8388600},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MIN,         1'b1, S_MIN},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    -24'sd1,       1'b1, -24'sd8},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd7,        1'b1, 24'sd0},
        '{ROW_CFG,    REG_MIX,       13'd4096, 24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd4194304,  1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    -24'sd4194304, 1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MAX,         1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MIN,         1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd1048576,  1'b0, 24'sd0},
        // effect off forces a dry output
        '{ROW_CFG,    REG_EFFECT_ON, 13'd0,    24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MAX,         1'b1, 24'sd8388600},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MIN,         1'b1, S_MIN},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd12345,    1'b1, 24'sd12344},
        '{ROW_CFG,    REG_EFFECT_ON, 13'd1,    24'sd0,        1'b0, 24'sd0},
        '{ROW_CFG,    REG_DRIVE,     13'd5120, 24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MAX,         1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    -24'sd1234567, 1'b0, 24'sd0},
        // zero drive, fully wet: wet is zero
        '{ROW_CFG,    REG_DRIVE,     13'd0,    24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MAX,         1'b1, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MIN,         1'b1, 24'sd0},
        // tiny drive saturates the makeup gain
        '{ROW_CFG,    REG_DRIVE,     13'd1,    24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MAX,         1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd3,        1'b0, 24'sd0},
        '{ROW_CFG,    REG_DRIVE,     13'd8191, 24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MIN,         1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd2097152,  1'b0, 24'sd0},
        '{ROW_CFG,    REG_MIX,       13'd8191, 24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    S_MAX,         1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    -24'sd2097152, 1'b0, 24'sd0},
        // write to an unmapped index is dropped
        '{ROW_CFG,    REG_UNUSED,    13'd8191, 24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd777777,   1'b0, 24'sd0},
        '{ROW_CFG,    REG_MIX,       13'd2048, 24'sd0,        1'b0, 24'sd0},
        '{ROW_CFG,    REG_DRIVE,     13'd256,  24'sd0,        1'b0, 24'sd0},
        '{ROW_SAMPLE, REG_EFFECT_ON, 13'd0,    24'sd5000000,  1'b0, 24'sd0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_sample                i_sample_in = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_sample                o_sample_out;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    logic                   effect_on;
    logic [DRIVE_W-1:0]     drive_gain;
    logic [MIX_W-1:0]       mix_amount;
    longint                 makeup_gain;

    t_sample                expected_out_q[$];
    int                     fail_count = 0;
    int                     idle_cycles = 0;
    bit                     no_gaps = 1'b0;

    rational_soft_clip_waveshaper uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor(num * 2^F / den), saturating on a zero divisor
    function automatic longint frac_quotient(input longint num, input longint den);
        logic [127:0] wide;
        if (den == 0) begin
            return QUOT_SAT;
        end
        wide = 128'(num) << FRAC_W;
        return longint'(wide / 128'(den));
    endfunction

    function automatic longint soft_curve_mag(input longint m);
        longint s2;
        longint num;
        longint den;
        s2  = (m * m) >>> FRAC_W;
        num = (m * (C27 + s2)) >>> FRAC_W;
        den = C27 + 9 * s2;
        return frac_quotient(num, den);
    endfunction

    function automatic longint makeup_for_drive(input logic [DRIVE_W-1:0] drv);
        longint g;
        g = frac_quotient(K_HEAD, soft_curve_mag(longint'(drv) <<< (FRAC_W - DRIVE_FRAC)));
        return (g > GAIN_MAX) ? GAIN_MAX : g;
    endfunction

    function automatic t_sample shaped_sample(input t_sample s);
        longint dry;
        longint x;
        longint m;
        longint w;
        longint wet;
        longint mix_eff;
        longint y;
        dry = longint'(s) >>> IN_SHIFT;
        x   = (dry * longint'(drive_gain)) >>> DRIVE_FRAC;
        m   = (x < 0) ? -x : x;
        w   = (soft_curve_mag(m) * makeup_gain) >>> FRAC_W;
        wet = (x < 0) ? -w : w;
        mix_eff = effect_on ? longint'(mix_amount) : longint'(0);
        y = dry + (((wet - dry) * mix_eff) >>> MIX_FRAC);
        y = y <<< IN_SHIFT;
        if (y > longint'(S_MAX)) begin
            y = longint'(S_MAX);
        end else if (y < longint'(S_MIN)) begin
            y = longint'(S_MIN);
        end
        return t_sample'(y);
    endfunction

    task automatic send_sample(input t_sample s, input t_sample want);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        repeat (gap) @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_sample_in = s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_out_q.push_back(want);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // registers change only once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        int gap;
        while (expected_out_q.size() != 0) @(negedge i_clk);
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        repeat (gap) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_EFFECT_ON: begin
                effect_on = val[0];
            end
            REG_DRIVE: begin
                drive_gain  = val;
                makeup_gain = makeup_for_drive(val);
            end
            REG_MIX: begin
                mix_amount = val;
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic check_sample_out(input t_sample got);
        t_sample want;
        if (expected_out_q.size() == 0) begin
            $error("sample_out: unexpected transfer, got %0d", got);
            fail_count++;
        end else begin
            want = expected_out_q.pop_front();
            if (got !== want) begin
                $error("sample_out mismatch: expected %0d, actual %0d", want, got);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int stall;
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            check_sample_out(o_sample_out);
            @(negedge i_clk);
        end
    end

    initial begin
        t_stim_row             row;
        t_sample               s;
        logic [DRIVE_W-1:0]    drv;
        logic [MIX_W-1:0]      mx;

        effect_on   = EFFECT_RESET;
        drive_gain  = DRIVE_RESET;
        mix_amount  = MIX_RESET;
        makeup_gain = makeup_for_drive(DRIVE_RESET);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            row = DIRECTED[r];
            if (row.kind == ROW_CFG) begin
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_sample(row.sample, row.known ? row.result : shaped_sample(row.sample));
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            no_gaps = (phase % 4 == 3);
            case ($urandom_range(0, 9))
                0:       drv = 13'd0;
                1:       drv = 13'd1;
                2:       drv = 13'd5120;
                3:       drv = 13'd256;
                4:       drv = 13'($urandom_range(5121, 8191));
                default: drv = 13'($urandom_range(256, 5120));
            endcase
            case ($urandom_range(0, 5))
                0:       mx = 13'd0;
                1:       mx = 13'd4096;
                2:       mx = 13'($urandom_range(4097, 8191));
                default: mx = 13'($urandom_range(0, 4096));
            endcase
            write_reg(REG_EFFECT_ON, 13'($urandom_range(0, 3) != 0));
            write_reg(REG_DRIVE, drv);
            write_reg(REG_MIX, mx);
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_UNUSED, 13'($urandom));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0: begin
                        case ($urandom_range(0, 3))
                            0:       s = S_MAX;
                            1:       s = S_MIN;
                            2:       s = '0;
                            default: s = -24'sd1;
                        endcase
                    end
                    1:       s = t_sample'($signed(9'($urandom)));
                    default: s = t_sample'($urandom);
                endcase
                send_sample(s, shaped_sample(s));
            end
        end

        no_gaps = 1'b0;
        while (expected_out_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rscw_pkg.sv
rtl/rscw_front.sv
rtl/rscw_divider.sv
rtl/rscw_back.sv
rtl/rscw_makeup.sv
rtl/rational_soft_clip_waveshaper.sv
verif/rational_soft_clip_waveshaper_tb.sv
